// File: design/sitoa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_pkg: shared constants for the signed integer to decimal text core
// Holds the value width, the derived digit count and the ASCII codes used.
// ----------------------------------------------------------------------------
package sitoa_pkg;

    // Width of the signed input value (8 to 64).
    localparam int VALUE_BITS = 32;

    // Decimal digits of 2^VALUE_BITS - 1, from floor(W * log10(2)) + 1.
    localparam int NUM_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;

    // Width of the packed BCD accumulator.
    localparam int BCD_BITS = NUM_DIGITS * 4;

    // Counter widths.
    localparam int CNT_W  = $clog2(VALUE_BITS);
    localparam int LEFT_W = $clog2(NUM_DIGITS + 1);

    // ASCII codes.
    localparam logic [6:0] CHAR_ZERO  = 7'd48;
    localparam logic [6:0] CHAR_MINUS = 7'd45;

    // Double-dabble correction threshold and offset for one BCD digit.
    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

endpackage

// File: design/signed_int_to_decimal_ascii_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core: signed integer to decimal ASCII text
// Converts one two's-complement value into its decimal characters, sign first.
// ----------------------------------------------------------------------------
// Each accepted value produces its decimal text one character per output
// transfer, most significant digit first, with a leading '-' for negative
// values, no leading zeros, a single '0' for zero, and o_last_char set on
// the final character. The magnitude is shifted one bit per cycle through a
// double-dabble BCD register; the sign, when present, is then emitted, and
// the BCD register is drained one digit per cycle unless a digit waits on an
// output stall (leading zeros are dropped without using the output). One item
// is converted at a time; the next value is accepted at the edge after the
// final character of the previous one has been loaded into the output
// register, even while that character still waits.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input channel.
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [sitoa_pkg::VALUE_BITS-1:0] i_value,
    // Output channel.
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [6:0]                      o_text_char,
    output logic                            o_last_char
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam int TOP = sitoa_pkg::BCD_BITS - 4;

    localparam logic [sitoa_pkg::LEFT_W-1:0] LEFT_W_ONE = sitoa_pkg::LEFT_W'(1);

    logic [1:0]                        r_state, n_state;
    logic [sitoa_pkg::VALUE_BITS-1:0]  r_mag, n_mag;
    logic                              r_neg, n_neg;
    logic [sitoa_pkg::BCD_BITS-1:0]    r_bcd, n_bcd;
    logic [sitoa_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic [sitoa_pkg::LEFT_W-1:0]      r_left, n_left;
    logic                              r_seen, n_seen;
    logic                              r_ovalid, n_ovalid;
    logic [6:0]                        r_char, n_char;
    logic                              r_last, n_last;

    logic [sitoa_pkg::BCD_BITS-1:0]    w_adj;
    logic [3:0]                        w_top;
    logic                              w_out_free;

    // Every BCD digit of 5 or more gets 3 added before the next left shift.
    always_comb begin
        for (int d = 0; d < sitoa_pkg::NUM_DIGITS; d++) begin
            if (r_bcd[d*4 +: 4] >= sitoa_pkg::BCD_ADJ_MIN) begin
                w_adj[d*4 +: 4] = r_bcd[d*4 +: 4] + sitoa_pkg::BCD_ADJ_ADD;
            end else begin
                w_adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    assign w_top      = r_bcd[TOP +: 4];
    assign w_out_free = !r_ovalid || !i_stall;

    always_comb begin
        n_state  = r_state;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_bcd    = r_bcd;
        n_cnt    = r_cnt;
        n_left   = r_left;
        n_seen   = r_seen;
        n_char   = r_char;
        n_last   = r_last;
        n_ovalid = r_ovalid && i_stall;

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    // The negated most negative value reads correctly as unsigned.
                    n_neg   = i_value[sitoa_pkg::VALUE_BITS-1];
                    n_mag   = n_neg ? (~i_value + 1'b1) : i_value;
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_bcd = {w_adj[sitoa_pkg::BCD_BITS-2:0], r_mag[sitoa_pkg::VALUE_BITS-1]};
                n_mag = {r_mag[sitoa_pkg::VALUE_BITS-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == sitoa_pkg::CNT_W'(sitoa_pkg::VALUE_BITS - 1)) begin
                    n_left  = sitoa_pkg::LEFT_W'(sitoa_pkg::NUM_DIGITS);
                    n_seen  = 1'b0;
                    n_state = r_neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_char   = sitoa_pkg::CHAR_MINUS;
                    n_last   = 1'b0;
                    n_state  = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_top == 4'd0 && !r_seen && r_left != LEFT_W_ONE) begin
                    // Leading zero: drop it without using the output.
                    n_bcd  = {r_bcd[TOP-1:0], 4'd0};
                    n_left = r_left - 1'b1;
                end else if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_char   = sitoa_pkg::CHAR_ZERO + {3'd0, w_top};
                    n_last   = (r_left == LEFT_W_ONE);
                    n_seen   = 1'b1;
                    n_bcd    = {r_bcd[TOP-1:0], 4'd0};
                    n_left   = r_left - 1'b1;
                    if (r_left == LEFT_W_ONE) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_bcd  <= n_bcd;
        r_cnt  <= n_cnt;
        r_left <= n_left;
        r_seen <= n_seen;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_ovalid;
    assign o_text_char = r_char;
    assign o_last_char = r_last;

`ifndef SYNTHESIS
    // A minus sign is never the final character.
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_text_char == sitoa_pkg::CHAR_MINUS |-> !o_last_char)
        else $error("minus sign flagged as last character");

    // A character that is not the last one leaves the core still draining digits.
    a_more_to_come: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_char |-> r_state == ST_EMIT)
        else $error("non-final character while not emitting digits");

    // The digit counter never runs out while digits are being drained.
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT |-> r_left != '0)
        else $error("digit counter exhausted in emit state");

    // The conversion leaves a valid decimal digit at the top of the BCD register.
    a_top_digit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT |-> w_top <= 4'd9)
        else $error("top BCD digit out of range");
`endif

endmodule

// File: sim/signed_int_to_decimal_ascii_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core_tb: self-checking bench for the text core
// Feeds signed values through the input channel and compares every character
// that leaves the output channel against a local model of decimal conversion.
// ----------------------------------------------------------------------------
// The run starts with a short table of directed values: zero, the most
// negative and most positive values, digit-count boundaries and alternating
// bit patterns. Rows whose text is obvious carry it typed in. All other rows
// and the random values that follow are checked against the local model.
// Both channels idle in random bursts, and the final stretch of the run is
// driven with no gaps and no output stall at all.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core_tb;

    // One expected character on the output channel.
    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } t_ascii_char;

    localparam int DIR_N       = 24;
    localparam int RAND_N      = 430;
    // The last values are sent back to back with the receiver never stalling.
    localparam int QUIET_N     = 60;
    // A little more than one full conversion at the configured width.
    localparam int DRAIN_TICKS = sitoa_pkg::VALUE_BITS + sitoa_pkg::NUM_DIGITS + 20;

    // All block inputs start at known values before the first edge.
    logic                             i_clk   = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_valid = 1'b0;
    logic [sitoa_pkg::VALUE_BITS-1:0] i_value = '0;
    logic                             i_stall = 1'b0;
    logic                             o_stall;
    logic                             o_valid;
    logic [6:0]                       o_text_char;
    logic                             o_last_char;

    // Expected characters in the order they must leave the block.
    t_ascii_char pending_chars[$];

    int  fail_count    = 0;
    int  chars_checked = 0;
    int  values_sent   = 0;
    int  negatives     = 0;
    bit  quiet_tail    = 1'b0;
    int  stall_ticks   = 0;

    // Directed table. An empty text means the local model supplies the result.
    longint dir_value [DIR_N];
    string  dir_text  [DIR_N];

    signed_int_to_decimal_ascii_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

    always #5 i_clk = ~i_clk;

    // Local model: sign, then magnitude digits from the most significant one.
    // The magnitude is one bit wider than the value so the most negative
    // value negates without wrapping.
    function automatic void predict_text(input logic [sitoa_pkg::VALUE_BITS-1:0] v);
        logic [sitoa_pkg::VALUE_BITS:0] mag;
        logic [3:0]                     digits[$];
        logic                           negative;
        t_ascii_char                    c;
        negative = v[sitoa_pkg::VALUE_BITS-1];
        mag      = negative ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
        do begin
            digits.push_front(4'(mag % 10));
            mag = mag / 10;
        end while (mag != 0);
        if (negative) begin
            c.code = sitoa_pkg::CHAR_MINUS;
            c.last = 1'b0;
            pending_chars.push_back(c);
        end
        for (int k = 0; k < digits.size(); k++) begin
            c.code = sitoa_pkg::CHAR_ZERO + 7'(digits[k]);
            c.last = (k == digits.size() - 1);
            pending_chars.push_back(c);
        end
    endfunction

    // Queues the characters of a text that was typed into the table.
    function automatic void queue_typed_text(input string s);
        t_ascii_char c;
        for (int k = 0; k < s.len(); k++) begin
            c.code = 7'(s[k]);
            c.last = (k == s.len() - 1);
            pending_chars.push_back(c);
        end
    endfunction

    // Random values lean on interesting magnitudes: every decimal length,
    // powers of ten and their neighbors, tiny numbers and the range ends.
    function automatic logic [sitoa_pkg::VALUE_BITS-1:0] pick_random_value();
        logic [63:0] wide;
        logic [63:0] pow10;
        int          k;
        logic        neg;
        wide  = {$urandom, $urandom};
        neg   = 1'($urandom_range(0, 1));
        pow10 = 64'd1;
        k     = $urandom_range(1, sitoa_pkg::NUM_DIGITS);
        for (int j = 0; j < k; j++) begin
            pow10 = pow10 * 10;
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                return wide[sitoa_pkg::VALUE_BITS-1:0];
            end
            4, 5, 6: begin
                wide = wide % pow10;
            end
            7: begin
                // A power of ten, or one either side of it.
                wide = pow10 + 64'($urandom_range(0, 2)) - 64'd1;
            end
            8: begin
                wide = 64'($urandom_range(0, 20));
            end
            default: begin
                // Close to the most negative or the most positive value.
                wide = {1'b0, {(sitoa_pkg::VALUE_BITS-1){1'b1}}}
                       - 64'($urandom_range(0, 3)) + 64'(neg);
            end
        endcase
        return neg ? -wide[sitoa_pkg::VALUE_BITS-1:0] : wide[sitoa_pkg::VALUE_BITS-1:0];
    endfunction

    // Presents one value and holds it until the block accepts the transfer.
    // The expected characters are queued at the accepting edge.
    task automatic send_value(input logic [sitoa_pkg::VALUE_BITS-1:0] v,
                              input string typed);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (typed != "" && sitoa_pkg::VALUE_BITS == 32) begin
            queue_typed_text(typed);
        end else begin
            predict_text(v);
        end
        values_sent++;
        if (v[sitoa_pkg::VALUE_BITS-1]) negatives++;
    endtask

    // Receiver side: alternating stretches of stall bursts and free running.
    // During the final stretch the receiver takes every character at once.
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet_tail) begin
            i_stall     <= 1'b0;
            stall_ticks <= 0;
        end else if (stall_ticks != 0) begin
            stall_ticks <= stall_ticks - 1;
        end else if (i_stall) begin
            i_stall     <= 1'b0;
            stall_ticks <= ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 12);
        end else begin
            i_stall     <= 1'b1;
            stall_ticks <= $urandom_range(1, 11) - 1;
        end
    end

    // Every accepted output transfer is matched against the oldest expectation.
    always @(posedge i_clk) begin : check_output
        t_ascii_char want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected character: text_char=%0d last_char=%0b",
                       o_text_char, o_last_char);
                fail_count++;
            end else begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (o_text_char !== want.code) begin
                    $error("text_char mismatch: expected %0d, actual %0d",
                           want.code, o_text_char);
                    fail_count++;
                end
                if (o_last_char !== want.last) begin
                    $error("last_char mismatch: expected %0b, actual %0b",
                           want.last, o_last_char);
                    fail_count++;
                end
            end
        end
    end

    initial begin : stimulus
        dir_value = '{
            0, -64'sd2147483648, 64'sd2147483647, -64'sd2147483647,
            -1, 1, 9, 10,
            -9, -10, 99, 100,
            1000000000, -1000000000, 999999999, 1234567890,
            -1234567890, 64'sd1431655765, -64'sd1431655766, 65535,
            -32768, 0, 0, 7
        };
        dir_text = '{
            "0", "-2147483648", "2147483647", "-2147483647",
            "-1", "1", "", "",
            "", "", "", "",
            "1000000000", "", "", "",
            "", "", "", "",
            "", "0", "0", ""
        };

        // Synchronous reset, held low from the start, and never asserted again.
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < DIR_N; n++) begin
            send_value(dir_value[n][sitoa_pkg::VALUE_BITS-1:0], dir_text[n]);
        end

        for (int n = 0; n < RAND_N; n++) begin
            if (n == RAND_N - QUIET_N) quiet_tail = 1'b1;
            send_value(pick_random_value(), "");
        end
        i_valid <= 1'b0;

        // Let the output drain, then watch a while longer for stray characters.
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TICKS) @(posedge i_clk);

        $display("Sent %0d values (%0d negative, %0d from the directed table).",
                 values_sent, negatives, DIR_N);
        $display("Compared %0d output characters under random idling and stall.",
                 chars_checked);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Far above the slowest legal run, even with every character stalled.
    initial begin : watchdog
        #5000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
